// ----- rtl/vmst_pkg.sv -----
// Shared types, codes and constants of the VM value and call stack unit.
package vmst_pkg;

	// Fixed data width of one stack value
	localparam int VALUE_WIDTH = 32;

	// Default sizes of the two stacks
	localparam int VALUE_DEPTH_DEF = 64;
	localparam int CALL_DEPTH_DEF  = 8;

	// Field widths
	localparam int OP_W     = 4;
	localparam int OFFSET_W = 8;
	localparam int PC_W     = 16;
	localparam int ERR_W    = 3;
	localparam int VDEPTH_W = 7;
	localparam int CDEPTH_W = 4;

	// Operation codes
	localparam logic [OP_W-1:0] OP_RESET  = 4'd0;
	localparam logic [OP_W-1:0] OP_PUSH   = 4'd1;
	localparam logic [OP_W-1:0] OP_POP    = 4'd2;
	localparam logic [OP_W-1:0] OP_PEEK   = 4'd3;
	localparam logic [OP_W-1:0] OP_DROP   = 4'd4;
	localparam logic [OP_W-1:0] OP_FREAD  = 4'd5;
	localparam logic [OP_W-1:0] OP_FWRITE = 4'd6;
	localparam logic [OP_W-1:0] OP_CALL   = 4'd7;
	localparam logic [OP_W-1:0] OP_RETURN = 4'd8;

	// Error codes
	localparam logic [ERR_W-1:0] ERR_OK         = 3'd0;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW   = 3'd1;
	localparam logic [ERR_W-1:0] ERR_UNDERFLOW  = 3'd2;
	localparam logic [ERR_W-1:0] ERR_ILLEGAL    = 3'd3;
	localparam logic [ERR_W-1:0] ERR_COVERFLOW  = 3'd4;
	localparam logic [ERR_W-1:0] ERR_CUNDERFLOW = 3'd5;

	// Input item
	typedef struct packed {
		logic [OP_W-1:0]               op;
		logic signed [VALUE_WIDTH-1:0] data_value;
		logic [OFFSET_W-1:0]           offset;
		logic [PC_W-1:0]               target_pc;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] read_value;
		logic [PC_W-1:0]               pc_now;
		logic [ERR_W-1:0]              error_code;
		logic [VDEPTH_W-1:0]           value_depth;
		logic [CDEPTH_W-1:0]           call_depth;
	} out_item_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WB
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic execute;
		logic finish;
	} cmd_t;

endpackage

// ----- rtl/vmst_ctrl.sv -----
// Controller of the VM stack unit: item sequencing and output handshake.
module vmst_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output vmst_pkg::cmd_t cmd
);
	import vmst_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_load;
	logic   capture;

	// Load the result register when the slot is free or being emptied
	assign out_load = (state_q == ST_WB) && (!out_valid_q || out_ready);
	assign capture  = in_valid && in_ready;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (capture) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_nxt = ST_WB;
			end
			ST_WB: begin
				if (out_load) begin
					state_nxt = capture ? ST_EXEC : ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		in_ready    = (state_q == ST_IDLE) || out_load;
		cmd.capture = capture;
		cmd.execute = (state_q == ST_EXEC);
		cmd.finish  = out_load;
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Hold the result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/vmst_dpath.sv -----
// Datapath of the VM stack unit: pointers, value memory, call memory, result register.
module vmst_dpath #(
	parameter int VALUE_DEPTH = vmst_pkg::VALUE_DEPTH_DEF,
	parameter int CALL_DEPTH  = vmst_pkg::CALL_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vmst_pkg::cmd_t      cmd,
	input  vmst_pkg::in_item_t  in_item,
	output vmst_pkg::out_item_t out_item
);
	import vmst_pkg::*;

	localparam int TW  = $clog2(VALUE_DEPTH + 1);
	localparam int AW  = $clog2(VALUE_DEPTH);
	localparam int EW  = ((TW > OFFSET_W) ? TW : OFFSET_W) + 1;
	localparam int CW  = $clog2(CALL_DEPTH + 1);
	localparam int CAW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;

	// Item and architectural state
	in_item_t         item_q;
	logic [TW-1:0]    value_top_q;
	logic [TW-1:0]    frame_base_q;
	logic [PC_W-1:0]  pc_q;
	logic [CW-1:0]    call_top_q;
	logic [ERR_W-1:0] err_q;
	logic             rd_sel_q;
	logic             ret_q;
	out_item_t        out_item_q;

	// Memories
	logic [VALUE_WIDTH-1:0] value_mem [VALUE_DEPTH];
	logic [PC_W-1:0]        ret_mem [CALL_DEPTH];
	logic [TW-1:0]          fb_mem [CALL_DEPTH];
	logic [VALUE_WIDTH-1:0] value_rdata_q;
	logic [PC_W-1:0]        ret_rdata_q;
	logic [TW-1:0]          fb_rdata_q;

	// Execute-stage signals
	logic [EW-1:0]          top_e;
	logic [EW-1:0]          off_e;
	logic [EW-1:0]          slot_e;
	logic [EW-1:0]          depth_e;
	logic [EW-1:0]          pop_addr_e;
	logic [EW-1:0]          peek_addr_e;
	logic [CW-1:0]          call_dec;
	logic                   top_full;
	logic                   call_full;
	logic [TW-1:0]          top_nxt;
	logic [TW-1:0]          fb_nxt;
	logic [PC_W-1:0]        pc_nxt;
	logic [CW-1:0]          call_nxt;
	logic [ERR_W-1:0]       err_nxt;
	logic                   rd_sel_nxt;
	logic                   ret_nxt;
	logic                   mem_we;
	logic                   mem_re;
	logic [EW-1:0]          mem_addr_e;
	logic [AW-1:0]          mem_addr;
	logic                   call_we;
	logic                   call_re;

	// Widen operands to one compare width
	assign top_e       = EW'(value_top_q);
	assign off_e       = EW'(item_q.offset);
	assign slot_e      = EW'(frame_base_q) + off_e;
	assign depth_e     = EW'(VALUE_DEPTH);
	assign pop_addr_e  = top_e - EW'(1);
	assign peek_addr_e = top_e - EW'(1) - off_e;
	assign call_dec    = call_top_q - CW'(1);
	assign top_full    = (value_top_q == TW'(VALUE_DEPTH));
	assign call_full   = (call_top_q == CW'(CALL_DEPTH));
	assign mem_addr    = mem_addr_e[AW-1:0];

	// Decode the operation and compute next pointers
	always_comb begin
		top_nxt    = value_top_q;
		fb_nxt     = frame_base_q;
		pc_nxt     = pc_q;
		call_nxt   = call_top_q;
		err_nxt    = ERR_OK;
		rd_sel_nxt = 1'b0;
		ret_nxt    = 1'b0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_addr_e = '0;
		call_we    = 1'b0;
		call_re    = 1'b0;
		case (item_q.op)
			OP_RESET: begin
				pc_nxt   = item_q.target_pc;
				top_nxt  = '0;
				fb_nxt   = '0;
				call_nxt = '0;
			end
			OP_PUSH: begin
				if (top_full) begin
					err_nxt = ERR_OVERFLOW;
				end else begin
					mem_we     = 1'b1;
					mem_addr_e = top_e;
					top_nxt    = value_top_q + TW'(1);
				end
			end
			OP_POP: begin
				if (value_top_q == '0) begin
					err_nxt = ERR_UNDERFLOW;
				end else begin
					mem_re     = 1'b1;
					rd_sel_nxt = 1'b1;
					mem_addr_e = pop_addr_e;
					top_nxt    = value_top_q - TW'(1);
				end
			end
			OP_PEEK: begin
				if (top_e > off_e) begin
					mem_re     = 1'b1;
					rd_sel_nxt = 1'b1;
					mem_addr_e = peek_addr_e;
				end else begin
					err_nxt = ERR_UNDERFLOW;
				end
			end
			OP_DROP: begin
				if (top_e >= off_e) begin
					top_nxt = TW'(top_e - off_e);
				end else begin
					err_nxt = ERR_UNDERFLOW;
				end
			end
			OP_FREAD: begin
				if (slot_e < top_e) begin
					mem_re     = 1'b1;
					rd_sel_nxt = 1'b1;
					mem_addr_e = slot_e;
				end else begin
					err_nxt = ERR_ILLEGAL;
				end
			end
			OP_FWRITE: begin
				if (slot_e < depth_e) begin
					mem_we     = 1'b1;
					mem_addr_e = slot_e;
				end else begin
					err_nxt = ERR_ILLEGAL;
				end
			end
			OP_CALL: begin
				if (call_full) begin
					err_nxt = ERR_COVERFLOW;
				end else begin
					call_we  = 1'b1;
					pc_nxt   = item_q.target_pc;
					fb_nxt   = value_top_q;
					call_nxt = call_top_q + CW'(1);
				end
			end
			OP_RETURN: begin
				if (call_top_q == '0) begin
					err_nxt = ERR_CUNDERFLOW;
				end else begin
					call_re  = 1'b1;
					ret_nxt  = 1'b1;
					call_nxt = call_dec;
					top_nxt  = frame_base_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_item;
		end
	end

	// Value memory: one port, registered read
	always_ff @(posedge clk) begin
		if (cmd.execute && mem_we) begin
			value_mem[mem_addr] <= item_q.data_value;
		end
		if (cmd.execute && mem_re) begin
			value_rdata_q <= value_mem[mem_addr];
		end
	end

	// Call memory: push at the top, read one below the top
	always_ff @(posedge clk) begin
		if (cmd.execute && call_we) begin
			ret_mem[call_top_q[CAW-1:0]] <= pc_q;
			fb_mem[call_top_q[CAW-1:0]]  <= frame_base_q;
		end
		if (cmd.execute && call_re) begin
			ret_rdata_q <= ret_mem[call_dec[CAW-1:0]];
			fb_rdata_q  <= fb_mem[call_dec[CAW-1:0]];
		end
	end

	// Update pointers on execute; restore frame and pc of a return on finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_top_q  <= '0;
			frame_base_q <= '0;
			pc_q         <= '0;
			call_top_q   <= '0;
			err_q        <= ERR_OK;
			rd_sel_q     <= 1'b0;
			ret_q        <= 1'b0;
		end else if (cmd.execute) begin
			value_top_q  <= top_nxt;
			frame_base_q <= fb_nxt;
			pc_q         <= pc_nxt;
			call_top_q   <= call_nxt;
			err_q        <= err_nxt;
			rd_sel_q     <= rd_sel_nxt;
			ret_q        <= ret_nxt;
		end else if (cmd.finish && ret_q) begin
			frame_base_q <= fb_rdata_q;
			pc_q         <= ret_rdata_q;
			ret_q        <= 1'b0;
		end
	end

	// Form the result item
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_item_q.read_value  <= rd_sel_q ? value_rdata_q : '0;
			out_item_q.pc_now      <= ret_q ? ret_rdata_q : pc_q;
			out_item_q.error_code  <= err_q;
			out_item_q.value_depth <= VDEPTH_W'(value_top_q);
			out_item_q.call_depth  <= CDEPTH_W'(call_top_q);
		end
	end

	assign out_item = out_item_q;

endmodule

// ----- rtl/vm_value_and_call_stack.sv -----
// Stack unit of a bytecode VM: value stack, frame pointer, pc and call stack.
//
// Input channel in_valid/in_ready carries one operation item (op, data_value,
// offset, target_pc); output channel out_valid/out_ready returns exactly one
// result item per operation (read_value, pc_now, error_code, value_depth,
// call_depth). Items are processed one at a time in order.
// Timing: an item accepted at edge N is executed in the following cycle
// (pointer checks, one value-memory or call-memory access); its result,
// built from the registered memory read, is then loaded into the output
// register once that register is free, which raises out_valid. The next
// item is taken in the cycle the result is loaded, so a new item is not
// accepted while the current one is still executing.
// When the receiver stalls, the result waits in the output register; the
// block then holds the executed item and takes no new one until the result
// register frees up.
// Reset clears the pointers, pc and call depth; memory contents are not
// cleared and no clearing pass is run. The op code reset does the same to the
// pointers and loads pc from target_pc.
module vm_value_and_call_stack #(
	parameter int VALUE_DEPTH = vmst_pkg::VALUE_DEPTH_DEF,
	parameter int CALL_DEPTH  = vmst_pkg::CALL_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  vmst_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output vmst_pkg::out_item_t out_item
);
	import vmst_pkg::*;

	cmd_t cmd;

	// Sequencing and handshake
	vmst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Stacks and result register
	vmst_dpath #(
		.VALUE_DEPTH (VALUE_DEPTH),
		.CALL_DEPTH  (CALL_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_item  (in_item),
		.out_item (out_item)
	);

endmodule
